FILE: hdl/alpha_blit_clip_blend_core_macros.svh
// assertion macros shared by the checker
`ifndef ALPHA_BLIT_CLIP_BLEND_CORE_MACROS_SVH
`define ALPHA_BLIT_CLIP_BLEND_CORE_MACROS_SVH

// same-cycle implication, muted while in reset
`define ABCB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("abcb assertion failed");

// next-cycle implication, muted while in reset
`define ABCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("abcb assertion failed");

// next-cycle implication that also covers the reset cycles
`define ABCB_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("abcb assertion failed");

`endif

FILE: hdl/abcb_pkg.sv
`timescale 1ns / 1ps

package abcb_pkg;

    localparam int DEST_MAX_WIDTH  = 64;
    localparam int DEST_MAX_HEIGHT = 64;
    localparam int SOURCE_MAX_SIDE = 64;

    localparam int STORE_DEPTH = DEST_MAX_WIDTH * DEST_MAX_HEIGHT;
    localparam int ADDR_W      = 12;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int ALPHA_LSB = 24;
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

    localparam int SIZE_W   = 7;
    localparam int OFS_W    = 8;
    localparam int SCOL_W   = $clog2(SOURCE_MAX_SIDE);
    localparam int DCOL_W   = $clog2(DEST_MAX_WIDTH);
    localparam int DROW_W   = $clog2(DEST_MAX_HEIGHT);
    localparam int POS_W    = ((OFS_W > SCOL_W + 1) ? OFS_W : SCOL_W + 1) + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int IN_TDATA_W   = ((PIX_W + 7) / 8) * 8;
    localparam int OUT_VAL_LSB  = ADDR_W;
    localparam int OUT_TDATA_W  = ((ADDR_W + PIX_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 2;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_WIDTH    = 3'd0,
        CFG_DEST_HEIGHT   = 3'd1,
        CFG_SOURCE_WIDTH  = 3'd2,
        CFG_SOURCE_HEIGHT = 3'd3,
        CFG_OFFSET_X      = 3'd4,
        CFG_OFFSET_Y      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic              in_frame;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  val;
        logic              eos;
    } out_item_t;

    typedef struct packed {
        logic             we;
        logic [PIX_W-1:0] val;
    } blend_res_t;

    // zero counts as one, anything above the limit as the limit
    function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: hdl/alpha_blit_clip_blend_core.sv
`timescale 1ns / 1ps

// channel   dir  tdata                                   tuser                 tlast
// s_axis    in   source_pixel[31:0]                      -                     -
// m_axis    out  dest_address[11:0], dest_value[43:12]   inside_res, write_en  end_of_source
// cfg       in   plain write: cfg_wr_en, cfg_addr, cfg_wdata
//
// one pixel per cycle sustained while m_axis is ready; a pixel is accepted, its frame store
// entry is read in that cycle, blended and written back in the next, and is then in the
// output queue; a write from the previous pixel is forwarded when it hits the same entry
// after reset a clearing pass writes zero to all 4096 entries, one per cycle, with
// s_axis_tready low; config writes are taken during that time
// m_axis stalls are absorbed by a three-entry output queue before s_axis_tready drops

module alpha_blit_clip_blend_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [abcb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // source_pixel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [abcb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // dest_address, dest_value
    output logic [abcb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,   // inside_res, write_enable
    output logic                                m_axis_tlast,
    input  logic                                cfg_wr_en,
    input  logic [abcb_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [abcb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import abcb_pkg::*;

    // configuration
    logic [SIZE_W-1:0]  dest_width_reg, dest_height_reg;
    logic [SIZE_W-1:0]  source_width_reg, source_height_reg;
    logic [OFS_W-1:0]   offset_x_reg, offset_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_width_reg    <= SIZE_W'(DEST_MAX_WIDTH);
            dest_height_reg   <= SIZE_W'(DEST_MAX_HEIGHT);
            source_width_reg  <= SIZE_W'(SOURCE_MAX_SIDE);
            source_height_reg <= SIZE_W'(SOURCE_MAX_SIDE);
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DEST_WIDTH:    dest_width_reg    <= cfg_wdata[SIZE_W-1:0];
                CFG_DEST_HEIGHT:   dest_height_reg   <= cfg_wdata[SIZE_W-1:0];
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_OFFSET_X:      offset_x_reg      <= cfg_wdata[OFS_W-1:0];
                CFG_OFFSET_Y:      offset_y_reg      <= cfg_wdata[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [SIZE_W-1:0] dw, dh, sw, sh;
    assign dw = fit_size(dest_width_reg, SIZE_W'(DEST_MAX_WIDTH));
    assign dh = fit_size(dest_height_reg, SIZE_W'(DEST_MAX_HEIGHT));
    assign sw = fit_size(source_width_reg, SIZE_W'(SOURCE_MAX_SIDE));
    assign sh = fit_size(source_height_reg, SIZE_W'(SOURCE_MAX_SIDE));

    // clearing pass
    logic                 clearing_reg, clearing_next;
    logic [STORE_AW-1:0]  clr_addr_reg, clr_addr_next;

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + STORE_AW'(1);
            if (clr_addr_reg == STORE_AW'(STORE_DEPTH - 1)) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // accept stage: position, clip and address
    logic                 s_fire;
    logic [SCOL_W-1:0]    col_reg, col_next;
    logic [SCOL_W-1:0]    row_reg, row_next;
    logic signed [POS_W-1:0] pos_x, pos_y;
    logic                 in_x, in_y, inside_a;
    logic                 last_col, last_row;
    logic [DROW_W+SIZE_W-1:0] row_base;
    logic [STORE_AW-1:0]  addr_a;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    always_comb begin
        pos_x = POS_W'($signed(offset_x_reg)) + $signed(POS_W'(col_reg));
        pos_y = POS_W'($signed(offset_y_reg)) + $signed(POS_W'(row_reg));
        in_x  = !pos_x[POS_W-1] && ($unsigned(pos_x) < POS_W'(dw));
        in_y  = !pos_y[POS_W-1] && ($unsigned(pos_y) < POS_W'(dh));
        inside_a = in_x && in_y;
        row_base = pos_y[DROW_W-1:0] * dw;
        addr_a   = STORE_AW'(row_base + (DROW_W+SIZE_W)'(pos_x[DCOL_W-1:0]));
        last_col = (SIZE_W'(col_reg) + SIZE_W'(1)) >= sw;
        last_row = (SIZE_W'(row_reg) + SIZE_W'(1)) >= sh;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_fire) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + SCOL_W'(1);
            end else begin
                col_next = col_reg + SCOL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // blend stage registers
    logic                 b_valid_reg;
    logic [PIX_W-1:0]     b_pix_reg;
    logic                 b_inside_reg;
    logic [STORE_AW-1:0]  b_addr_reg;
    logic                 b_eos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            b_pix_reg    <= s_axis_tdata[PIX_W-1:0];
            b_inside_reg <= inside_a;
            b_addr_reg   <= addr_a;
            b_eos_reg    <= last_col && last_row;
        end
    end

    // frame store, read-first
    logic [PIX_W-1:0]     store_mem [STORE_DEPTH];
    logic [PIX_W-1:0]     rd_data_reg;
    logic                 mem_we;
    logic [STORE_AW-1:0]  mem_waddr;
    logic [PIX_W-1:0]     mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (s_fire) begin
            rd_data_reg <= store_mem[addr_a];
        end
    end

    // forward the previous pixel's write; its read went out in the same cycle
    logic                 fwd_valid_reg, fwd_valid_next;
    logic [STORE_AW-1:0]  fwd_addr_reg;
    logic [PIX_W-1:0]     fwd_data_reg;
    logic [PIX_W-1:0]     dst_b;
    blend_res_t           blend_res;
    logic                 b_we;

    assign dst_b = (fwd_valid_reg && (fwd_addr_reg == b_addr_reg)) ? fwd_data_reg
                                                                    : rd_data_reg;

    abcb_blend u_blend (
        .src_pixel (b_pix_reg),
        .dst_pixel (dst_b),
        .res       (blend_res)
    );

    assign b_we           = b_valid_reg && b_inside_reg && blend_res.we;
    assign fwd_valid_next = b_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= b_addr_reg;
        fwd_data_reg <= blend_res.val;
    end

    always_comb begin
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = b_we;
            mem_waddr = b_addr_reg;
            mem_wdata = blend_res.val;
        end
    end

    // output queue
    out_item_t            b_item, head;
    logic                 q_not_empty, m_fire;
    logic [FIFO_CW-1:0]   q_count;

    always_comb begin
        b_item.in_frame = b_inside_reg;
        b_item.we       = b_inside_reg && blend_res.we;
        b_item.addr     = b_inside_reg ? ADDR_W'(b_addr_reg) : '0;
        b_item.val      = b_inside_reg ? blend_res.val : '0;
        b_item.eos      = b_eos_reg;
    end

    assign m_fire = m_axis_tvalid && m_axis_tready;

    abcb_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (b_valid_reg),
        .push_item (b_item),
        .pop       (m_fire),
        .head      (head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    // room for every pixel already in flight plus this one
    assign s_axis_tready = !clearing_reg
        && ((FIFO_CW+1)'(q_count) + (FIFO_CW+1)'(b_valid_reg)
            <= (FIFO_CW+1)'(FIFO_DEPTH - 1));

    assign m_axis_tvalid = q_not_empty;
    assign m_axis_tdata  = OUT_TDATA_W'({head.val, head.addr});
    assign m_axis_tuser  = {head.we, head.in_frame};
    assign m_axis_tlast  = head.eos;

endmodule

FILE: hdl/abcb_blend.sv
`timescale 1ns / 1ps

module abcb_blend (
    input  logic [abcb_pkg::PIX_W-1:0] src_pixel,
    input  logic [abcb_pkg::PIX_W-1:0] dst_pixel,
    output abcb_pkg::blend_res_t       res
);
    import abcb_pkg::*;

    logic [CH_W-1:0]     alpha;
    logic [CH_W-1:0]     inv_alpha;
    logic [2*CH_W-1:0]   mix   [NUM_CH];
    logic [2*CH_W:0]     rnd   [NUM_CH];
    logic [PIX_W-1:0]    mixed;

    assign alpha     = src_pixel[ALPHA_LSB +: CH_W];
    assign inv_alpha = ALPHA_OPAQUE - alpha;

    // divide by 255 as (v + 1 + (v >> 8)) >> 8, exact for every v up to 65534
    always_comb begin
        mixed = '0;
        mixed[ALPHA_LSB +: CH_W] = ALPHA_OPAQUE;
        for (int i = 0; i < NUM_CH; i++) begin
            mix[i] = src_pixel[i*CH_W +: CH_W] * alpha
                   + dst_pixel[i*CH_W +: CH_W] * inv_alpha;
            rnd[i] = (2*CH_W+1)'(mix[i]) + (2*CH_W+1)'(1)
                   + (2*CH_W+1)'(mix[i] >> CH_W);
            mixed[i*CH_W +: CH_W] = rnd[i][CH_W +: CH_W];
        end
    end

    always_comb begin
        res.we = (alpha != ALPHA_CLEAR);
        if (alpha == ALPHA_OPAQUE) begin
            res.val = src_pixel;
        end else if (alpha == ALPHA_CLEAR) begin
            res.val = dst_pixel;
        end else begin
            res.val = mixed;
        end
    end

endmodule

FILE: hdl/abcb_out_fifo.sv
`timescale 1ns / 1ps

module abcb_out_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  abcb_pkg::out_item_t           push_item,
    input  logic                          pop,
    output abcb_pkg::out_item_t           head,
    output logic                          not_empty,
    output logic [abcb_pkg::FIFO_CW-1:0]  count
);
    import abcb_pkg::*;

    out_item_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;

    function automatic logic [FIFO_PW-1:0] bump(input logic [FIFO_PW-1:0] p);
        logic [FIFO_PW-1:0] r;
        if (p == FIFO_PW'(FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + FIFO_PW'(1);
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

FILE: hdl/abcb_checker.sv
`timescale 1ns / 1ps
`include "alpha_blit_clip_blend_core_macros.svh"

module abcb_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [abcb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic [abcb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    input logic                                m_axis_tlast
);
    import abcb_pkg::*;

    // the clearing pass holds off input right after reset
    `ABCB_ASSERT_RST(a_clear_blocks_input, !aresetn, !s_axis_tready)

    // a clipped pixel reports no write, address zero and value zero
    `ABCB_ASSERT_NOW(a_outside_zero, m_axis_tvalid && !m_axis_tuser[0], !m_axis_tuser[1] && m_axis_tdata == '0)

    // a write lies inside and never stores a fully transparent pixel
    `ABCB_ASSERT_NOW(a_write_inside, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0] && m_axis_tdata[OUT_VAL_LSB+ALPHA_LSB +: CH_W] != '0)

    // a stalled transaction stays put
    `ABCB_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

endmodule

bind alpha_blit_clip_blend_core abcb_checker u_abcb_checker (.*);

FILE: bench/alpha_blit_clip_blend_core_tb.sv
`timescale 1ns / 1ps

module alpha_blit_clip_blend_core_tb;
    import abcb_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int TOTAL_PIXELS   = 1850;
    localparam int TAIL_PIXELS    = 120;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_CYCLES = 600000;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

    alpha_blit_clip_blend_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    // predictor copy of the frame, counters and registers
    logic [PIX_W-1:0]        dest_frame [STORE_DEPTH];
    int                      src_col = 0;
    int                      src_row = 0;
    logic [SIZE_W-1:0]       reg_dest_w = 7'd64;
    logic [SIZE_W-1:0]       reg_dest_h = 7'd64;
    logic [SIZE_W-1:0]       reg_src_w  = 7'd64;
    logic [SIZE_W-1:0]       reg_src_h  = 7'd64;
    logic signed [OFS_W-1:0] reg_ofs_x  = '0;
    logic signed [OFS_W-1:0] reg_ofs_y  = '0;

    out_item_t predicted_dest [$];
    int        mismatch_count = 0;
    int        pixels_sent    = 0;
    int        gap_pct        = 20;
    int        stall_pct      = 20;
    int        hold_ticket    = 0;

    function automatic int side_limit(input logic [SIZE_W-1:0] v, input int cap);
        return (v == 0) ? 1 : ((int'(v) > cap) ? cap : int'(v));
    endfunction

    // place one source pixel, merge it into the frame copy, advance the raster counters
    function automatic out_item_t place_pixel(input logic [PIX_W-1:0] pix);
        int               dw, dh, sw, sh, x, y, a, mix;
        logic [PIX_W-1:0] cur;
        out_item_t        res;
        dw  = side_limit(reg_dest_w, DEST_MAX_WIDTH);
        dh  = side_limit(reg_dest_h, DEST_MAX_HEIGHT);
        sw  = side_limit(reg_src_w, SOURCE_MAX_SIDE);
        sh  = side_limit(reg_src_h, SOURCE_MAX_SIDE);
        x   = int'(reg_ofs_x) + src_col;
        y   = int'(reg_ofs_y) + src_row;
        res = '0;
        res.in_frame = (x >= 0) && (y >= 0) && (x < dw) && (y < dh);
        res.eos      = (src_col + 1 >= sw) && (src_row + 1 >= sh);
        if (res.in_frame) begin
            res.addr = ADDR_W'(y * dw + x);
            cur      = dest_frame[res.addr];
            a        = int'(pix[ALPHA_LSB +: CH_W]);
            if (a == int'(ALPHA_OPAQUE)) begin
                cur    = pix;
                res.we = 1'b1;
            end else if (a != int'(ALPHA_CLEAR)) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    mix = (int'(pix[i*CH_W +: CH_W]) * a
                           + int'(cur[i*CH_W +: CH_W]) * (255 - a)) / 255;
                    cur[i*CH_W +: CH_W] = mix[CH_W-1:0];
                end
                cur[ALPHA_LSB +: CH_W] = ALPHA_OPAQUE;
                res.we = 1'b1;
            end
            if (res.we) begin
                dest_frame[res.addr] = cur;
            end
            res.val = cur;
        end
        // a counter left past a shrunk size counts as the last position
        if (src_col + 1 >= sw) begin
            src_col = 0;
            src_row = (src_row + 1 >= sh) ? 0 : src_row + 1;
        end else begin
            src_col++;
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [CH_W-1:0] a;
        case ($urandom_range(7))
            0, 1: a = ALPHA_OPAQUE;
            2: a = ALPHA_CLEAR;
            3: a = $urandom_range(1) ? 8'h01 : 8'hFE;
            default: a = CH_W'($urandom);
        endcase
        return {a, 24'($urandom)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_side();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return 8'd0;
                    1: return 8'd1;
                    2: return 8'd64;
                    3: return 8'd127;
                    default: return 8'd200;
                endcase
            end
            1, 2, 3, 4, 5: return CFG_DATA_W'($urandom_range(1, 8));
            default: return CFG_DATA_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_offset();
        case ($urandom_range(9))
            0: return 8'h80;
            1: return 8'h7F;
            2, 3: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, 16) - 8);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [PIX_W-1:0] want, got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // sink side: random stall bursts plus the long hold-off on request
    int stall_left = 0;
    int hold_left  = 0;
    int hold_taken = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_ticket != hold_taken) begin
            hold_taken = hold_ticket;
            hold_left  = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (predicted_dest.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got %h %h %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = predicted_dest.pop_front();
                check_field("inside_res", want.in_frame, m_axis_tuser[0]);
                check_field("write_enable", want.we, m_axis_tuser[1]);
                check_field("dest_address", want.addr, m_axis_tdata[ADDR_W-1:0]);
                check_field("dest_value", want.val, m_axis_tdata[OUT_VAL_LSB +: PIX_W]);
                check_field("end_of_source", want.eos, m_axis_tlast);
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted_dest.push_back(place_pixel(pix));
        pixels_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (predicted_dest.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaves the write enable high so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_DEST_WIDTH:    reg_dest_w = data[SIZE_W-1:0];
            CFG_DEST_HEIGHT:   reg_dest_h = data[SIZE_W-1:0];
            CFG_SOURCE_WIDTH:  reg_src_w  = data[SIZE_W-1:0];
            CFG_SOURCE_HEIGHT: reg_src_h  = data[SIZE_W-1:0];
            CFG_OFFSET_X:      reg_ofs_x  = data;
            CFG_OFFSET_Y:      reg_ofs_y  = data;
            default: ;
        endcase
    endtask

    task automatic apply_setup(input logic [CFG_DATA_W-1:0] dw, dh, sw, sh, ox, oy);
        write_reg(CFG_DEST_WIDTH, dw);
        write_reg(CFG_DEST_HEIGHT, dh);
        write_reg(CFG_SOURCE_WIDTH, sw);
        write_reg(CFG_SOURCE_HEIGHT, sh);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_setup();
        apply_setup(pick_side(), pick_side(), pick_side(), pick_side(),
                    pick_offset(), pick_offset());
    endtask

    // copy, skip and blend on a 3x2 source shifted left by one and down by two
    task automatic test_blend_rules();
        logic [PIX_W-1:0] pixels [10] = '{
            32'hFF123456, 32'hFFFFFFFF, 32'h80A0B0C0,
            32'h00000000, 32'hFFFFFFFF, 32'h7F000000,
            32'h01FFFFFF, 32'h00ABCDEF, 32'hFE00FF00, 32'h01010101
        };
        apply_setup(8'd4, 8'd3, 8'd3, 8'd2, 8'hFF, 8'd2);
        foreach (pixels[i]) send_pixel(pixels[i]);
        wait_drained();
    endtask

    // zero and oversize register values, offsets at both ends
    task automatic test_size_limits();
        apply_setup(8'd0, 8'hFF, 8'h80, 8'd0, 8'd0, 8'd63);
        send_pixel(32'hFF112233);
        send_pixel(32'h40FFFFFF);
        send_pixel(32'h00ABCDEF);
        wait_drained();
        write_reg(CFG_OFFSET_X, 8'h80);
        cfg_wr_en <= 1'b0;
        send_pixel(32'hFFFFFFFF);
        wait_drained();
        write_reg(CFG_OFFSET_X, 8'h7F);
        cfg_wr_en <= 1'b0;
        send_pixel(32'hFF000000);
        wait_drained();
    endtask

    task automatic test_spare_index();
        write_reg(CFG_SPARE_6, 8'h01);
        write_reg(CFG_SPARE_7, 8'hFE);
        cfg_wr_en <= 1'b0;
        send_pixel(random_pixel());
        send_pixel(random_pixel());
        wait_drained();
    endtask

    // shrink the source while the counters sit past the new edge
    task automatic test_mid_image_resize();
        apply_setup(8'd16, 8'd16, 8'd8, 8'd8, 8'd2, 8'd2);
        repeat (5) send_pixel(random_pixel());
        wait_drained();
        write_reg(CFG_SOURCE_WIDTH, 8'd3);
        write_reg(CFG_OFFSET_X, 8'hFE);
        cfg_wr_en <= 1'b0;
        repeat (2) send_pixel(random_pixel());
        wait_drained();
        write_reg(CFG_SOURCE_HEIGHT, 8'd1);
        cfg_wr_en <= 1'b0;
        repeat (3) send_pixel(random_pixel());
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        apply_setup(8'd8, 8'd8, 8'd4, 8'd4, 8'd1, 8'd1);
        gap_pct = 0;
        hold_ticket <= hold_ticket + 1;
        repeat (40) send_pixel(random_pixel());
        wait_drained();
    endtask

    task automatic test_random_blits();
        int n;
        while (pixels_sent < TOTAL_PIXELS - TAIL_PIXELS) begin
            random_setup();
            case ($urandom_range(3))
                0: gap_pct = 0;
                1: gap_pct = 5;
                2: gap_pct = 20;
                default: gap_pct = 50;
            endcase
            case ($urandom_range(3))
                0: stall_pct = 0;
                1: stall_pct = 5;
                2: stall_pct = 20;
                default: stall_pct = 50;
            endcase
            n = $urandom_range(1, 120);
            repeat (n) send_pixel(random_pixel());
            wait_drained();
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_steady_stream();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (2) begin
            random_setup();
            repeat (TAIL_PIXELS / 2) send_pixel(random_pixel());
            wait_drained();
        end
    endtask

    initial begin
        foreach (dest_frame[i]) dest_frame[i] = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_blend_rules();
        test_size_limits();
        test_spare_index();
        test_mid_image_resize();
        test_output_backpressure();
        test_random_blits();
        test_steady_stream();
        wait_drained();
        if (mismatch_count == 0 && predicted_dest.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: alpha_blit_clip_blend_core.f
+incdir+hdl
hdl/abcb_pkg.sv
hdl/abcb_blend.sv
hdl/abcb_out_fifo.sv
hdl/alpha_blit_clip_blend_core.sv
hdl/abcb_checker.sv
bench/alpha_blit_clip_blend_core_tb.sv
